>>> hdl/shs_pkg.sv
// shared types and constants of the sha-256 stream hasher
// holds the queue entry type, initial hash values and round constants
// no dependencies
package shs_pkg;

  // default number of entries in the queue between front and engine
  localparam int QUEUE_DEPTH = 4;

  // one classified request as it travels from front to engine
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       eom;
  } shs_item_t;

  // initial chaining value
  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // round constants
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

>>> hdl/sha256_stream_hasher.sv
// top level of the sha-256 stream hasher
// instantiates shs_front and shs_engine; depends on shs_pkg
//
// usage:
// - input channel (item_valid / item_stall) carries one request per cycle while
//   item_stall is low: data_byte with byte_valid, and end_of_message on the last
//   request of a message; a request with neither flag is dropped
// - output channel (digest_valid / digest_stall) gives eight digest words
//   per message, word_index 0 first, last_word on word 7
// - a small queue (QueueDepth entries) sits between the input and the engine;
//   item_stall rises only when that queue is full
// - the engine takes one queued byte per cycle while idle; every 64th byte
//   starts a compression (64 rounds at one per cycle, one chaining add), and
//   no further byte is taken until the compression is done
// - with the engine idle, an end mark passes the queue, the padding step, the
//   compression and the output load before the first digest word appears; a
//   second compression is added when the padding spills (56 or more
//   bytes in the last block); then one word per cycle while digest_stall is low
// - the digest sits in an output register; a stall holds it and the engine
//   waits, while the front keeps queuing bytes of the next message
// - synchronous reset empties the queue, restores the initial hash values
//   and clears the length count; no clearing pass is needed
module sha256_stream_hasher #(
  parameter int QueueDepth = shs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  shs_pkg::shs_item_t q_item;
  logic               q_valid;
  logic               q_pop;

  shs_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .end_of_message(end_of_message),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_pop         (q_pop)
  );

  shs_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .digest_valid(digest_valid),
    .digest_stall(digest_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  // engine never pops an empty queue
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");

  // a request carrying a byte or end mark is visible to the engine next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && (byte_valid || end_of_message)) |=> q_valid)
    else $error("queued request lost");

  // digest words come out without gaps once the first one is taken
  a_digest_burst: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_stall && !last_word) |=> digest_valid)
    else $error("gap inside digest burst");

  // word 7 is the only one flagged last
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

endmodule

>>> hdl/shs_front.sv
// input side of the sha-256 stream hasher: accepts requests, drops idle ones
// and queues bytes and end marks for the engine
// depends on shs_pkg
module shs_front #(
  parameter int QueueDepth = shs_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [7:0]        data_byte,
  input  logic              byte_valid,
  input  logic              end_of_message,
  output shs_pkg::shs_item_t q_item,
  output logic              q_valid,
  input  logic              q_pop
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  shs_pkg::shs_item_t queue_mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;

  // a request with neither byte nor end mark changes nothing
  assign item_stall = (count == CntW'(QueueDepth));
  assign push       = item_valid && !item_stall && (byte_valid || end_of_message);
  assign q_valid    = (count != '0);
  assign q_item     = queue_mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= '{data_byte: data_byte, byte_valid: byte_valid,
                             eom: end_of_message};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/shs_engine.sv
// back end of the sha-256 stream hasher: packs bytes, pads, runs the
// 64 compression rounds one per cycle and emits the digest words
// depends on shs_pkg
module shs_engine (
  input  logic               clk,
  input  logic               rst,
  input  shs_pkg::shs_item_t q_item,
  input  logic               q_valid,
  output logic               q_pop,
  output logic               digest_valid,
  input  logic               digest_stall,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  state_t      state;
  logic [31:0] hash_cv [8];
  logic [31:0] working [8];
  logic [31:0] sched [16];
  logic [63:0] bit_count;
  logic [5:0]  round_cnt;
  logic [2:0]  out_idx;
  logic        eom_pend;
  logic        len_pend;
  logic        final_blk;

  logic [5:0]  pos;
  logic [3:0]  word_sel;
  logic [4:0]  shamt;
  logic [7:0]  ins_byte;
  logic [31:0] merged_word;
  logic        pad_spill;
  logic        block_full;
  logic        load_work;
  logic        out_load;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // byte position within the current block
  assign pos       = bit_count[8:3];
  assign word_sel  = pos[5:2];
  assign shamt     = {2'(2'd3 - pos[1:0]), 3'b000};
  assign pad_spill = (pos[5:3] == 3'b111);

  // byte insertion, shared by message bytes and the 0x80 pad byte
  assign ins_byte    = (state == S_PAD) ? 8'h80 : q_item.data_byte;
  assign merged_word = (pos[1:0] == 2'b00) ? {ins_byte, 24'h0}
                     : (sched[word_sel] | ({24'h0, ins_byte} << shamt));

  assign q_pop      = (state == S_IDLE) && q_valid;
  assign block_full = q_pop && q_item.byte_valid && (pos == 6'd63);
  assign load_work  = block_full || (state == S_PAD) || (state == S_LEN);
  assign out_load   = (state == S_OUT) && (!digest_valid || !digest_stall);

  // round logic on the sliding schedule window
  assign w_new = sched[0] + ssig0(sched[1]) + sched[9] + ssig1(sched[14]);
  assign t1 = working[7] + bsig1(working[4])
            + ((working[4] & working[5]) ^ (~working[4] & working[6]))
            + shs_pkg::ROUND_K[round_cnt] + sched[0];
  assign t2 = bsig0(working[0])
            + ((working[0] & working[1]) ^ (working[0] & working[2])
               ^ (working[1] & working[2]));

  // schedule buffer and working variables
  always_ff @(posedge clk) begin
    if (load_work) begin
      working <= hash_cv;
    end
    unique case (state)
      S_IDLE: begin
        if (q_pop && q_item.byte_valid) begin
          sched[word_sel] <= merged_word;
        end
      end
      S_PAD: begin
        // length words go in place when the pad byte leaves room for them
        for (int i = 0; i < 16; i++) begin
          if (4'(i) == word_sel) begin
            sched[i] <= merged_word;
          end else if (!pad_spill && i == 14) begin
            sched[i] <= bit_count[63:32];
          end else if (!pad_spill && i == 15) begin
            sched[i] <= bit_count[31:0];
          end else if (4'(i) > word_sel) begin
            sched[i] <= '0;
          end
        end
      end
      S_LEN: begin
        for (int i = 0; i < 14; i++) begin
          sched[i] <= '0;
        end
        sched[14] <= bit_count[63:32];
        sched[15] <= bit_count[31:0];
      end
      S_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          sched[i] <= sched[i+1];
        end
        sched[15]  <= w_new;
        working[7] <= working[6];
        working[6] <= working[5];
        working[5] <= working[4];
        working[4] <= working[3] + t1;
        working[3] <= working[2];
        working[2] <= working[1];
        working[1] <= working[0];
        working[0] <= t1 + t2;
      end
      default: begin
      end
    endcase
  end

  // sequencer, chaining value and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      hash_cv      <= shs_pkg::INIT_HASH;
      bit_count    <= '0;
      round_cnt    <= '0;
      out_idx      <= '0;
      eom_pend     <= 1'b0;
      len_pend     <= 1'b0;
      final_blk    <= 1'b0;
      digest_valid <= 1'b0;
    end else begin
      // output register valid: set on each load, cleared once taken
      if (out_load) begin
        digest_valid <= 1'b1;
      end else if (!digest_stall) begin
        digest_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_item.byte_valid) begin
              bit_count <= bit_count + 64'd8;
            end
            eom_pend <= q_item.eom;
            if (block_full) begin
              state <= S_ROUND;
            end else if (q_item.eom) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          eom_pend  <= 1'b0;
          len_pend  <= pad_spill;
          final_blk <= !pad_spill;
          state     <= S_ROUND;
        end
        S_LEN: begin
          len_pend  <= 1'b0;
          final_blk <= 1'b1;
          state     <= S_ROUND;
        end
        S_ROUND: begin
          round_cnt <= round_cnt + 1'b1;
          if (round_cnt == 6'd63) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash_cv[i] <= hash_cv[i] + working[i];
          end
          priority if (eom_pend) begin
            state <= S_PAD;
          end else if (len_pend) begin
            state <= S_LEN;
          end else if (final_blk) begin
            out_idx <= '0;
            state   <= S_OUT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_load) begin
            digest_word  <= hash_cv[out_idx];
            word_index   <= out_idx;
            last_word    <= (out_idx == 3'd7);
            out_idx      <= out_idx + 1'b1;
            if (out_idx == 3'd7) begin
              hash_cv   <= shs_pkg::INIT_HASH;
              bit_count <= '0;
              final_blk <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
